>>> hw/rtl/ghr_pkg.sv
// Package for the generational handle registry.
// Holds sizes, function and state codes, and the slot record type.
// No dependencies.
`default_nettype none
package ghr_pkg;
  localparam int SLOTS    = 64;
  localparam int IDX_W    = 6;
  localparam int GEN_W    = 16;
  localparam int KEY_W    = 64;
  localparam int KIND_W   = 8;
  localparam int CNT_W    = 7;
  localparam int HDL_W    = GEN_W + IDX_W;
  localparam int FUNC_W   = 3;

  typedef enum logic [FUNC_W-1:0] {
    F_ADD = 3'd0,
    F_RMH = 3'd1,
    F_RMK = 3'd2,
    F_LKH = 3'd3,
    F_HOK = 3'd4,
    F_CNT = 3'd5
  } func_e;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_SCAN  = 2'd1,
    S_WRITE = 2'd2,
    S_DONE  = 2'd3
  } state_e;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [KEY_W-1:0]  key;
    logic [GEN_W-1:0]  gen;
  } slot_t;

  // Controls for the slot ring: shift strobe and data fed into the tail
  typedef struct packed {
    logic  shift;
    slot_t data;
  } ring_ctl_t;
endpackage
`default_nettype wire

>>> hw/rtl/ghr_req_if.sv
// Request channel interface of the generational handle registry.
// Depends on ghr_pkg.
`default_nettype none
interface ghr_req_if import ghr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [KEY_W-1:0]  device_key;
  logic [KIND_W-1:0] device_kind;
  logic [HDL_W-1:0]  handle_in;

  modport source (output valid, func, device_key, device_kind, handle_in, input ready);
  modport sink   (input valid, func, device_key, device_kind, handle_in, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/ghr_rsp_if.sv
// Response channel interface of the generational handle registry.
// Depends on ghr_pkg.
`default_nettype none
interface ghr_rsp_if import ghr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              status;
  logic [HDL_W-1:0]  handle_out;
  logic [KIND_W-1:0] kind_out;
  logic [KEY_W-1:0]  key_out;
  logic [CNT_W-1:0]  type_count;
  logic [CNT_W-1:0]  total_count;

  modport source (output valid, status, handle_out, kind_out, key_out, type_count,
                  total_count, input ready);
  modport sink   (input valid, status, handle_out, kind_out, key_out, type_count,
                  total_count, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/generational_handle_registry.sv
// Top level of the generational handle registry: a ring of slot cells and
// its sequencer. Depends on ghr_pkg, ghr_req_if, ghr_rsp_if, ghr_cell, ghr_ctrl.
//
//   port         dir  handshake           content
//   req_i        in   valid/ready         func, device_key, device_kind, handle_in
//   rsp_o        out  valid/ready         status, handles, kind, key, counts
//   cfg_we_i     in   write enable        slots_in_use (cfg_wdata_i)
//
// Each transaction is taken in S_IDLE, rotates the 64-cell ring once in S_SCAN and
// posts its result in S_DONE. An accepted add takes a second rotation (S_WRITE) to
// write the free slot. The ring rotation sets the rate.
// Reset clears all slots at once; a new transaction is taken while a result waits.
`default_nettype none
module generational_handle_registry import ghr_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  ghr_req_if.sink               req_i,
  ghr_rsp_if.source             rsp_o,
  input  wire logic             cfg_we_i,
  input  wire logic [CNT_W-1:0] cfg_wdata_i
);
  slot_t     chain [SLOTS];
  ring_ctl_t ring;

  ghr_ctrl u_ctrl (
    .clk_i, .rst_ni, .req_i, .rsp_o, .cfg_we_i, .cfg_wdata_i,
    .head_i (chain[0]),
    .ring_o (ring)
  );

  // Build the ring; the tail takes the rewritten head record
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    if (i == SLOTS - 1) begin : g_tail
      ghr_cell u_cell (.clk_i, .rst_ni, .shift_i(ring.shift), .slot_i(ring.data),
                       .slot_o(chain[i]));
    end else begin : g_body
      ghr_cell u_cell (.clk_i, .rst_ni, .shift_i(ring.shift), .slot_i(chain[i+1]),
                       .slot_o(chain[i]));
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/ghr_cell.sv
// One slot of the registry ring: holds kind, key and generation.
// Loads its neighbor's record on each shift. Depends on ghr_pkg.
`default_nettype none
module ghr_cell import ghr_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  shift_i,
  input  wire slot_t slot_i,
  output slot_t      slot_o
);
  slot_t slot_q;

  // Advance the record one place along the ring
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else if (shift_i) begin
      slot_q <= slot_i;
    end
  end

  assign slot_o = slot_q;
endmodule
`default_nettype wire

>>> hw/rtl/ghr_ctrl.sv
// Sequencer of the registry: examines the record at the ring head on each
// shift and rewrites it. Depends on ghr_pkg, ghr_req_if, ghr_rsp_if.
`default_nettype none
module ghr_ctrl import ghr_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  ghr_req_if.sink           req_i,
  ghr_rsp_if.source         rsp_o,
  input  wire logic         cfg_we_i,
  input  wire logic [CNT_W-1:0] cfg_wdata_i,
  input  wire slot_t        head_i,
  output ring_ctl_t         ring_o
);
  state_e state_q, state_d;
  logic [IDX_W-1:0]  idx_q, idx_d, free_idx_q, free_idx_d;
  logic [FUNC_W-1:0] func_q, func_d;
  logic [KEY_W-1:0]  key_q, key_d, kout_key_q, kout_key_d;
  logic [KIND_W-1:0] kind_q, kind_d, kout_kind_q, kout_kind_d;
  logic [HDL_W-1:0]  hdl_q, hdl_d, hout_q, hout_d;
  logic              found_q, found_d, free_found_q, free_found_d, add_ok_q, add_ok_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d, total_q, total_d, siu_q;
  logic              ov_q, ov_d, st_q, st_d;
  logic [HDL_W-1:0]  oh_q, oh_d;
  logic [KIND_W-1:0] ok_q, ok_d;
  logic [KEY_W-1:0]  okey_q, okey_d;
  logic [CNT_W-1:0]  oc_q, oc_d, ot_q, ot_d;

  logic [CNT_W-1:0]  cap;
  logic              in_cap, last, match, live, key_ok, out_free;
  logic [GEN_W-1:0]  gen_inc;

  localparam logic [IDX_W-1:0] LastIdx = IDX_W'(SLOTS - 1);

  assign cap      = (siu_q > CNT_W'(SLOTS)) ? CNT_W'(SLOTS) : siu_q;
  assign in_cap   = {1'b0, idx_q} < siu_q;
  assign last     = (idx_q == LastIdx);
  assign key_ok   = (total_q != '0) && (key_q != '0);
  assign match    = in_cap && !found_q && (head_i.key == key_q);
  assign live     = in_cap && (total_q != '0) && (idx_q == hdl_q[IDX_W-1:0])
                    && (head_i.kind != '0) && (head_i.key != '0)
                    && (head_i.gen == hdl_q[HDL_W-1:IDX_W]);
  assign gen_inc  = head_i.gen + GEN_W'(1);
  assign out_free = !ov_q || rsp_o.ready;

  // Hold the slot count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      siu_q <= CNT_W'(SLOTS);
    end else if (cfg_we_i) begin
      siu_q <= cfg_wdata_i;
    end
  end

  // Process the head record and collect the result
  always_comb begin
    idx_d = idx_q; free_idx_d = free_idx_q; func_d = func_q; key_d = key_q;
    kind_d = kind_q; hdl_d = hdl_q; hout_d = hout_q; found_d = found_q;
    free_found_d = free_found_q; add_ok_d = add_ok_q; cnt_d = cnt_q;
    total_d = total_q; kout_key_d = kout_key_q; kout_kind_d = kout_kind_q;
    ov_d = ov_q && !rsp_o.ready; st_d = st_q; oh_d = oh_q; ok_d = ok_q;
    okey_d = okey_q; oc_d = oc_q; ot_d = ot_q;
    ring_o.data  = head_i;
    ring_o.shift = (state_q == S_SCAN) || (state_q == S_WRITE);
    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          func_d = req_i.func; key_d = req_i.device_key; kind_d = req_i.device_kind;
          hdl_d = req_i.handle_in; idx_d = '0; free_idx_d = '0; hout_d = '0;
          found_d = 1'b0; free_found_d = 1'b0; add_ok_d = 1'b0; cnt_d = '0;
          kout_key_d = '0; kout_kind_d = '0;
        end
      end
      S_SCAN: begin
        idx_d = idx_q + IDX_W'(1);
        if (in_cap && !free_found_q && head_i.key == '0) begin
          free_found_d = 1'b1;
          free_idx_d   = idx_q;
        end
        case (func_q)
          F_ADD: if (match) found_d = 1'b1;
          F_RMK: begin
            if (match && key_ok) begin
              found_d = 1'b1;
              ring_o.data.kind = '0;
              ring_o.data.key  = '0;
              total_d = total_q - CNT_W'(1);
            end
          end
          F_HOK: begin
            if (match && key_ok) begin
              found_d = 1'b1;
              hout_d  = {head_i.gen, idx_q};
            end
          end
          F_RMH: begin
            if (live) begin
              found_d = 1'b1;
              ring_o.data.kind = '0;
              ring_o.data.key  = '0;
              total_d = total_q - CNT_W'(1);
            end
          end
          F_LKH: begin
            if (live) begin
              found_d     = 1'b1;
              kout_kind_d = head_i.kind;
              kout_key_d  = head_i.key;
            end
          end
          F_CNT: begin
            if (in_cap && kind_q != '0 && head_i.kind == kind_q && head_i.key != '0) begin
              cnt_d = cnt_q + CNT_W'(1);
            end
          end
          default: ;
        endcase
        add_ok_d = (total_q < cap) && (kind_q != '0) && (key_q != '0)
                   && !found_d && free_found_d;
      end
      S_WRITE: begin
        idx_d = idx_q + IDX_W'(1);
        if (idx_q == free_idx_q) begin
          ring_o.data.kind = kind_q;
          ring_o.data.key  = key_q;
          ring_o.data.gen  = gen_inc;
          hout_d  = {gen_inc, idx_q};
          total_d = total_q + CNT_W'(1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          ov_d = 1'b1; oh_d = hout_q; ok_d = kout_kind_q; okey_d = kout_key_q;
          oc_d = cnt_q; ot_d = total_q;
          case (func_q)
            F_ADD:                      st_d = !add_ok_q;
            F_RMH, F_RMK, F_LKH, F_HOK: st_d = !found_q;
            F_CNT:                      st_d = 1'b0;
            default:                    st_d = 1'b1;
          endcase
        end
      end
      default: ;
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (req_i.valid) state_d = S_SCAN;
      S_SCAN:  begin
        if (last) state_d = (func_q == F_ADD && add_ok_d) ? S_WRITE : S_DONE;
      end
      S_WRITE: if (last) state_d = S_DONE;
      S_DONE:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Handshake and response fields
  always_comb begin
    req_i.ready  = (state_q == S_IDLE);
    rsp_o.valid  = ov_q;
    rsp_o.status = st_q;
    rsp_o.handle_out  = oh_q;
    rsp_o.kind_out    = ok_q;
    rsp_o.key_out     = okey_q;
    rsp_o.type_count  = oc_q;
    rsp_o.total_count = ot_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      total_q <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      total_q <= total_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    free_idx_q <= free_idx_d; func_q <= func_d; key_q <= key_d; kind_q <= kind_d;
    hdl_q <= hdl_d; hout_q <= hout_d; found_q <= found_d; free_found_q <= free_found_d;
    add_ok_q <= add_ok_d; cnt_q <= cnt_d; kout_key_q <= kout_key_d;
    kout_kind_q <= kout_kind_d; st_q <= st_d; oh_q <= oh_d; ok_q <= ok_d;
    okey_q <= okey_d; oc_q <= oc_d; ot_q <= ot_d;
  end

`ifndef SYNTH
  a_total_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= CNT_W'(SLOTS)) else $error("occupancy above slot count");
  a_idx_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN || state_q == S_WRITE) |=> idx_q == $past(idx_q) + IDX_W'(1))
    else $error("ring index did not advance");
  a_idle_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE || state_q == S_DONE) |=> total_q == $past(total_q))
    else $error("occupancy changed outside a pass");
  a_write_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WRITE) |-> (func_q == F_ADD && add_ok_q && free_found_q))
    else $error("write pass without a valid add");
`endif
endmodule
`default_nettype wire
